// ===== hw/rtl/fsyn_pkg.sv =====
// Shared types and constants for the Fourier series synthesis block.
// No dependencies; the sine ROM, the MAC and the top level in hw/rtl import this package.
`timescale 1ns / 1ps
`default_nettype none

package fsyn_pkg;

    localparam int CFG_W      = 9;   // coef_count register
    localparam int IDX_W      = 8;   // coef_index field
    localparam int COEF_W     = 32;  // Q16.16 coefficient and sum parts
    localparam int ANGLE_W    = 16;  // angle in 1/65536 of a turn
    localparam int SIN_W      = 16;  // signed sine table sample
    localparam int MUL_B_W    = 17;  // second multiplier operand, signed
    localparam int PROD_W     = COEF_W + MUL_B_W;
    localparam int FRAC_SHIFT = 15;  // sine samples are Q1.15
    localparam int SIN_MAG    = 32767;

    localparam int IN_DATA_W  = IDX_W + 2 * COEF_W + ANGLE_W;
    localparam int OUT_DATA_W = 2 * COEF_W;

    // What to do with the product that leaves the multiplier register
    typedef enum logic [1:0] {
        ACC_NONE   = 2'd0,
        ACC_ADD_RE = 2'd1,
        ACC_SUB_RE = 2'd2,
        ACC_ADD_IM = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        logic    acc_clr;
        acc_op_t op;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fsyn_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, unfolded to a full turn.
// Depends on fsyn_pkg for sample widths.
`timescale 1ns / 1ps
`default_nettype none

module fsyn_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rd_en,
    input  wire logic [TABLE_BITS-1:0]               idx,
    output logic signed [fsyn_pkg::SIN_W-1:0]        q
);
    import fsyn_pkg::*;

    localparam int  QTR      = 1 << (TABLE_BITS - 2);
    localparam int  QA_W     = TABLE_BITS - 1;
    localparam real STEP_RAD = 1.5707963267948966 / QTR;

    function automatic int quarter_entry(input int pos);
        real val;
        val = 32767.0 * $sin(STEP_RAD * pos);
        return $rtoi(val + 0.5);
    endfunction

    logic [SIN_W-2:0] tbl [0:QTR];

    for (genvar g = 0; g <= QTR; g++)
    begin : g_tbl
        assign tbl[g] = (SIN_W - 1)'(quarter_entry(g));
    end

    logic [1:0]            quad;
    logic [QA_W-1:0]       offs;
    logic [QA_W-1:0]       addr;
    logic signed [SIN_W-1:0] mag;

    assign quad = idx[TABLE_BITS-1 -: 2];
    assign offs = QA_W'(idx[TABLE_BITS-3:0]);
    // fold the second and fourth quadrants back onto the stored quarter
    assign addr = quad[0] ? (QA_W'(QTR) - offs) : offs;
    assign mag  = {1'b0, tbl[addr]};

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q <= quad[1] ? -mag : mag;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fsyn_mac.sv =====
// Shared signed multiplier with product register and complex accumulator.
// Depends on fsyn_pkg for widths, acc_op_t and mac_ctrl_t.
`timescale 1ns / 1ps
`default_nettype none

module fsyn_mac #(
    parameter int ACC_W = 43
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire fsyn_pkg::mac_ctrl_t                   ctrl,
    input  wire logic signed [fsyn_pkg::COEF_W-1:0]    op_a,
    input  wire logic signed [fsyn_pkg::MUL_B_W-1:0]   op_b,
    output logic [fsyn_pkg::ANGLE_W-1:0]               prod_lo,
    output logic signed [ACC_W-1:0]                    acc_re,
    output logic signed [ACC_W-1:0]                    acc_im
);
    import fsyn_pkg::*;

    localparam int SC_W = PROD_W - FRAC_SHIFT;

    logic signed [PROD_W-1:0] prod_reg;
    acc_op_t                  pend_reg;
    logic signed [SC_W-1:0]   scaled;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;

    // arithmetic shift of the product: floor division by 2^15
    assign scaled  = prod_reg[PROD_W-1:FRAC_SHIFT];
    assign term    = ACC_W'(scaled);
    assign prod_lo = prod_reg[ANGLE_W-1:0];
    assign acc_re  = acc_re_reg;
    assign acc_im  = acc_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= ACC_NONE;
        end
        else
        begin
            pend_reg <= ctrl.mul_en ? ctrl.op : ACC_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            case (pend_reg)
                ACC_ADD_RE: acc_re_reg <= acc_re_reg + term;
                ACC_SUB_RE: acc_re_reg <= acc_re_reg - term;
                ACC_ADD_IM: acc_im_reg <= acc_im_reg + term;
                default:    ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fourier_series_synthesis.sv =====
// Top level: coefficient store, sequencer and stream ports of the series evaluator.
// Depends on fsyn_pkg, fsyn_sine_rom and fsyn_mac.
//
//   Channel   Direction  Handshake                     Payload
//   cfg       in         cfg_we (no back-pressure)     cfg_wdata = coef_count
//   s_axis    in         s_axis_tvalid/s_axis_tready   tuser = action, tdata = load/angle
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata = sum_real, sum_imag
//
// A load word is written to the store and the block stays ready.
// An evaluate word runs the 2*m terms (m = half the capped coefficient
// count) through one shared 32x17 multiplier, four products per term,
// one term after the other.
// The result waits in an output register; the block accepts new words while it
// waits, and only the final hand-over stalls on m_axis_tready.
// Reset clears the count register, the sequencer and the output valid; the
// coefficient store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fourier_series_synthesis #(
    parameter int MAX_COEFFS = 256,
    parameter int TABLE_BITS = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // coef_count write
    input  wire logic                                cfg_we,
    input  wire logic [fsyn_pkg::CFG_W-1:0]          cfg_wdata,
    // input words
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [7:0] coef_index, [39:8] coef_real, [71:40] coef_imag, [87:72] angle_turns
    input  wire logic [fsyn_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] action: 0 load, 1 evaluate
    input  wire logic                                s_axis_tuser,
    // result words
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] sum_real, [63:32] sum_imag
    output logic [fsyn_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);
    import fsyn_pkg::*;

    localparam int AW    = $clog2(MAX_COEFFS);
    localparam int CNT_W = $clog2(MAX_COEFFS + 1);
    localparam int ACC_W = 34 + CNT_W;
    localparam int QTR   = 1 << (TABLE_BITS - 2);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_PHASE = 7'b0000100,
        ST_ADDR  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // clamp a wide accumulator into signed 32 bits
    function automatic logic [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[ACC_W-1:COEF_W-1];
        all_zeros = ~|v[ACC_W-1:COEF_W-1];
        if (all_ones || all_zeros)
            return v[COEF_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(COEF_W - 1){1'b0}}};
        else
            return {1'b0, {(COEF_W - 1){1'b1}}};
    endfunction

    // input word fields
    logic [IDX_W-1:0]   in_index;
    logic [COEF_W-1:0]  in_real;
    logic [COEF_W-1:0]  in_imag;
    logic [ANGLE_W-1:0] in_angle;

    assign in_index = s_axis_tdata[IDX_W-1:0];
    assign in_real  = s_axis_tdata[IDX_W +: COEF_W];
    assign in_imag  = s_axis_tdata[IDX_W + COEF_W +: COEF_W];
    assign in_angle = s_axis_tdata[IDX_W + 2 * COEF_W +: ANGLE_W];

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        count_reg;
    logic [ANGLE_W-1:0]      angle_reg, angle_next;
    logic [CNT_W-1:0]        terms_reg, terms_next;
    logic [CNT_W-1:0]        term_reg, term_next;
    logic [1:0]              step_reg, step_next;
    logic [ANGLE_W-1:0]      phase_reg, phase_next;
    logic [2*COEF_W-1:0]     coef_q_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_valid_reg;

    logic                    in_acc;
    logic                    do_load;
    logic                    rd_en;
    logic                    out_load;
    logic [CNT_W-1:0]        n_cap;
    logic [TABLE_BITS-1:0]   sin_idx;
    logic [TABLE_BITS-1:0]   cos_idx;
    logic signed [SIN_W-1:0] sin_q;
    logic signed [SIN_W-1:0] cos_q;
    logic signed [COEF_W-1:0]  coef_re;
    logic signed [COEF_W-1:0]  coef_im;
    logic signed [COEF_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0] op_b;
    mac_ctrl_t               mac_ctrl;
    logic [ANGLE_W-1:0]      prod_lo;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;

    logic [2*COEF_W-1:0]     coef_mem [MAX_COEFFS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign do_load       = in_acc && !s_axis_tuser && (32'(in_index) < MAX_COEFFS);

    // counts above the store depth act as the depth; the odd one is dropped
    assign n_cap = (32'(count_reg) > MAX_COEFFS) ? CNT_W'(MAX_COEFFS) : CNT_W'(count_reg);

    assign sin_idx = phase_reg[ANGLE_W-1 -: TABLE_BITS];
    assign cos_idx = sin_idx + TABLE_BITS'(QTR);

    assign coef_re = coef_q_reg[COEF_W-1:0];
    assign coef_im = coef_q_reg[2*COEF_W-1:COEF_W];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // coefficient store: written by load words, read one term at a time
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            coef_mem[AW'(in_index)] <= {in_imag, in_real};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            coef_q_reg <= coef_mem[term_reg[AW-1:0]];
        end
    end

    fsyn_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_sin_rom (
        .clk   (clk),
        .rd_en (rd_en),
        .idx   (sin_idx),
        .q     (sin_q)
    );

    fsyn_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_cos_rom (
        .clk   (clk),
        .rd_en (rd_en),
        .idx   (cos_idx),
        .q     (cos_q)
    );

    fsyn_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod_lo (prod_lo),
        .acc_re  (acc_re),
        .acc_im  (acc_im)
    );

    // Sequencer. Per term: re += a*cos, re -= b*sin, im += a*sin, im += b*cos,
    // each product accumulated in the cycle after it is formed.
    always_comb
    begin
        state_next = state_reg;
        angle_next = angle_reg;
        terms_next = terms_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        op_a       = coef_re;
        op_b       = MUL_B_W'(cos_q);
        mac_ctrl   = '{mul_en: 1'b0, acc_clr: 1'b0, op: ACC_NONE};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_axis_tuser)
                begin
                    angle_next = in_angle;
                    terms_next = {n_cap[CNT_W-1:1], 1'b0};
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // m*t gives the phase of the first term, k = -m
                op_a             = COEF_W'(terms_reg >> 1);
                op_b             = {1'b0, angle_reg};
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_clr = 1'b1;
                term_next        = '0;
                step_next        = '0;
                state_next       = (terms_reg == '0) ? ST_DONE : ST_PHASE;
            end
            ST_PHASE:
            begin
                phase_next = ANGLE_W'(0) - prod_lo;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                rd_en      = 1'b1;
                term_next  = term_reg + 1'b1;
                phase_next = phase_reg + angle_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                step_next       = step_reg + 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        op_a        = coef_re;
                        op_b        = MUL_B_W'(cos_q);
                        mac_ctrl.op = ACC_ADD_RE;
                    end
                    2'd1:
                    begin
                        op_a        = coef_im;
                        op_b        = MUL_B_W'(sin_q);
                        mac_ctrl.op = ACC_SUB_RE;
                    end
                    2'd2:
                    begin
                        op_a        = coef_re;
                        op_b        = MUL_B_W'(sin_q);
                        mac_ctrl.op = ACC_ADD_IM;
                    end
                    default:
                    begin
                        op_a        = coef_im;
                        op_b        = MUL_B_W'(cos_q);
                        mac_ctrl.op = ACC_ADD_IM;
                        // fetch the next term under the last product
                        if (term_reg == terms_reg)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            term_next  = term_reg + 1'b1;
                            phase_next = phase_reg + angle_reg;
                        end
                    end
                endcase
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        terms_reg <= terms_next;
        term_reg  <= term_next;
        step_reg  <= step_next;
        phase_reg <= phase_next;
        if (out_load)
        begin
            out_data_reg <= {sat32(acc_im), sat32(acc_re)};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fsyn_checker.sv =====
// Port-level checks on the Fourier series synthesis top level, bound to it.
// Depends on fourier_series_synthesis port names only.
`timescale 1ns / 1ps
`default_nettype none

module fsyn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // an evaluate word drops ready in the next cycle
    a_busy_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("ready held high straight after an evaluate word");

    // a load word never blocks the input side
    a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
        else $error("ready dropped after a load word");

    // a waiting result stays offered
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // a waiting result keeps its value
    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind fourier_series_synthesis fsyn_checker u_fsyn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
